// ===== rtl/mlp_pkg.sv =====
// Package: word types, constants and fixed-point helpers for the MLP regressor.
package mlp_pkg;

  typedef struct packed {
    logic               req_type;
    logic [6:0]         coef_addr;
    logic signed [31:0] coef_value;
    logic signed [31:0] absorb_254;
    logic signed [31:0] absorb_550;
    logic signed [31:0] water_temp;
  } mlp_req_t;

  typedef struct packed {
    logic signed [31:0] cod_value;
    logic signed [31:0] uv254_value;
  } mlp_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] dividend;
    logic signed [31:0] divisor;
  } mlp_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] quot;
  } mlp_div_rsp_t;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_PREDICT = 1'b1;

  localparam logic [16:0] TanhSat = 17'd65492;

  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -48'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [47:0] s;
    s = 48'(a) + 48'(b);
    return sat48(s);
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [47:0] s;
    s = 48'(a) - 48'(b);
    return sat48(s);
  endfunction

  function automatic logic signed [31:0] qmul_sat(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p >>> 16;
    if (t > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (t < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return t[31:0];
  endfunction

  function automatic logic [15:0] tanh_tab(input logic [3:0] idx);
    case (idx)
      4'd0:    return 16'd0;
      4'd1:    return 16'd30286;
      4'd2:    return 16'd49911;
      4'd3:    return 16'd59320;
      4'd4:    return 16'd63179;
      4'd5:    return 16'd64659;
      4'd6:    return 16'd65212;
      4'd7:    return 16'd65417;
      default: return 16'd65492;
    endcase
  endfunction

  function automatic logic signed [31:0] tanh_pl(input logic signed [31:0] x);
    logic [32:0] ax;
    logic [2:0]  seg;
    logic [14:0] frac;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [30:0] pr;
    logic [16:0] y;
    ax = x[31] ? (~{x[31], x} + 33'd1) : {1'b0, x};
    if (ax >= 33'h4_0000) begin
      y = TanhSat;
    end else begin
      seg  = ax[17:15];
      frac = ax[14:0];
      lo   = tanh_tab({1'b0, seg});
      hi   = tanh_tab({1'b0, seg} + 4'd1);
      pr   = 31'(16'(hi - lo)) * 31'(frac);
      y    = 17'(lo) + 17'(pr >> 15);
    end
    return x[31] ? -32'(y) : 32'(y);
  endfunction

endpackage

// ===== rtl/mlp_div.sv =====
// Restoring divider: saturated (d * 65536) / s, truncated toward zero, one bit a cycle.
module mlp_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mlp_pkg::mlp_div_req_t req_i,
  output mlp_pkg::mlp_div_rsp_t rsp_o
);
  import mlp_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [47:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [32:0] rem_sh;
  logic [31:0] da;
  logic [31:0] sa;
  logic signed [31:0] quot;

  assign da = req_i.dividend[31] ? 32'(-req_i.dividend) : 32'(req_i.dividend);
  assign sa = req_i.divisor[31] ? 32'(-req_i.divisor) : 32'(req_i.divisor);
  assign rem_sh = {rem_q[31:0], num_q[47]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (!busy_q && req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd48;
      num_d  = {da, 16'd0};
      rem_d  = '0;
      den_d  = sa;
      neg_d  = req_i.dividend[31] ^ req_i.divisor[31];
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        num_d = {num_q[46:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        num_d = {num_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  always_comb begin
    if (neg_q) begin
      if (num_q > 48'h8000_0000) begin
        quot = 32'sh8000_0000;
      end else begin
        quot = -(num_q[31:0]);
      end
    end else begin
      if (num_q > 48'h7FFF_FFFF) begin
        quot = 32'sh7FFF_FFFF;
      end else begin
        quot = num_q[31:0];
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot;

endmodule

// ===== rtl/two_layer_mlp_regressor_core.sv =====
// Top level: coefficient memory, hidden memory, shared multiply-accumulate and sequencer.
// A load word writes one coefficient and is taken whenever the core is idle. A predict
// word runs 3 + 3*H + 2*H multiply-accumulates on one shared 32x32 multiplier, each as a
// memory read, a multiply and an accumulate step, plus bias, minimum and scale reads, and
// two restoring divisions; an output whose scale is zero skips its division and gives
// zero. The input is not ready from accept until the result is loaded into the output
// register; a result waits in that register until taken, and a following predict word
// holds before its result while that register is full.
module two_layer_mlp_regressor_core #(
  parameter int HIDDEN_SIZE = 16,
  parameter int COEF_DEPTH  = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mlp_pkg::mlp_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mlp_pkg::mlp_rsp_t out_data_o
);
  import mlp_pkg::*;

  localparam int AW   = $clog2(COEF_DEPTH);
  localparam int LW   = $clog2(6 * HIDDEN_SIZE + 12);
  localparam int IW   = ((AW > LW) ? AW : LW) + 1;
  localparam int HW   = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_EX, S_ACC, S_DIV, S_FIN} state_e;
  typedef enum logic [1:0] {PH_SCL, PH_HID, PH_OUT} phase_e;
  typedef enum logic [1:0] {ST_MAC, ST_BIAS, ST_MIN, ST_DSC} step_e;

  state_e state_q;
  phase_e phase_q;
  step_e  step_q;
  logic [HW-1:0] i_q;
  logic [1:0]    j_q;
  logic          k_q;

  logic signed [31:0] x_q [3];
  logic signed [31:0] xs_q [3];
  logic signed [31:0] acc_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] res_q [2];
  logic               out_valid_q;
  mlp_rsp_t           out_q;

  logic signed [31:0] coef_mem [COEF_DEPTH];
  logic signed [31:0] hid_mem [HIDDEN_SIZE];
  logic signed [31:0] crd_q;
  logic               cok_q;
  logic signed [31:0] hrd_q;

  logic [IW-1:0]      idx;
  logic [IW-1:0]      hh;
  logic [IW-1:0]      ii;
  logic [IW-1:0]      jj;
  logic [10:0]        wa;
  logic               wr_en;
  logic               hid_we;
  logic signed [31:0] hid_wd;
  logic signed [31:0] cval;
  logic signed [31:0] opnd;
  logic signed [31:0] sum;
  logic               accept;
  logic               last_i;
  logic               out_load;

  mlp_div_req_t div_req;
  mlp_div_rsp_t div_rsp;

  assign hh = IW'(HIDDEN_SIZE);
  assign ii = IW'(i_q);
  assign jj = IW'(j_q);

  always_comb begin
    case (phase_q)
      PH_SCL: begin
        idx = (step_q == ST_MAC) ? (IW'(6) * hh + IW'(2) + jj) : (IW'(6) * hh + IW'(5) + jj);
      end
      PH_HID: begin
        idx = (step_q == ST_MAC) ? (ii * IW'(3) + jj) : (IW'(3) * hh + ii);
      end
      PH_OUT: begin
        case (step_q)
          ST_MAC:  idx = IW'(4) * hh + (k_q ? hh : '0) + ii;
          ST_BIAS: idx = IW'(6) * hh + IW'(k_q);
          ST_MIN:  idx = IW'(6) * hh + IW'(8) + IW'(k_q);
          default: idx = IW'(6) * hh + IW'(10) + IW'(k_q);
        endcase
      end
      default: idx = '0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;
  assign wa     = 11'(in_data_i.coef_addr);
  assign wr_en  = accept && (in_data_i.req_type == REQ_LOAD) && (wa < 11'(COEF_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      coef_mem[wa[AW-1:0]] <= in_data_i.coef_value;
    end
    crd_q <= coef_mem[idx[AW-1:0]];
    cok_q <= (idx < IW'(COEF_DEPTH));
  end

  always_ff @(posedge clk_i) begin
    if (hid_we) begin
      hid_mem[i_q] <= hid_wd;
    end
    hrd_q <= hid_mem[i_q];
  end

  assign cval     = cok_q ? crd_q : 32'sd0;
  assign sum      = sat_add(acc_q, cval);
  assign hid_we   = (state_q == S_EX) && (step_q == ST_BIAS) && (phase_q == PH_HID);
  assign hid_wd   = tanh_pl(sum);
  assign last_i   = (i_q == HW'(HIDDEN_SIZE - 1));
  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    case (phase_q)
      PH_SCL:  opnd = x_q[j_q];
      PH_HID:  opnd = xs_q[j_q];
      default: opnd = hrd_q;
    endcase
  end

  assign div_req.start    = (state_q == S_EX) && (step_q == ST_DSC) && (cval != 32'sd0);
  assign div_req.dividend = acc_q;
  assign div_req.divisor  = cval;

  mlp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_SCL;
      step_q      <= ST_MAC;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && (in_data_i.req_type == REQ_PREDICT)) begin
            x_q[0]  <= in_data_i.absorb_254;
            x_q[1]  <= in_data_i.absorb_550;
            x_q[2]  <= in_data_i.water_temp;
            acc_q   <= '0;
            phase_q <= PH_SCL;
            step_q  <= ST_MAC;
            i_q     <= '0;
            j_q     <= '0;
            k_q     <= 1'b0;
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_EX;
        end
        S_EX: begin
          state_q <= S_RD;
          case (step_q)
            ST_MAC: begin
              prod_q  <= 64'(opnd) * 64'(cval);
              state_q <= S_ACC;
            end
            ST_BIAS: begin
              case (phase_q)
                PH_SCL: begin
                  xs_q[j_q] <= sum;
                  acc_q     <= '0;
                  step_q    <= ST_MAC;
                  if (j_q == 2'd2) begin
                    phase_q <= PH_HID;
                    j_q     <= '0;
                    i_q     <= '0;
                  end else begin
                    j_q <= j_q + 2'd1;
                  end
                end
                PH_HID: begin
                  acc_q  <= '0;
                  j_q    <= '0;
                  step_q <= ST_MAC;
                  if (last_i) begin
                    phase_q <= PH_OUT;
                    i_q     <= '0;
                    k_q     <= 1'b0;
                  end else begin
                    i_q <= i_q + HW'(1);
                  end
                end
                default: begin
                  acc_q  <= sum;
                  step_q <= ST_MIN;
                end
              endcase
            end
            ST_MIN: begin
              acc_q  <= sat_sub(acc_q, cval);
              step_q <= ST_DSC;
            end
            default: begin
              if (cval == 32'sd0) begin
                res_q[k_q] <= '0;
                if (k_q) begin
                  state_q <= S_FIN;
                end else begin
                  k_q    <= 1'b1;
                  i_q    <= '0;
                  acc_q  <= '0;
                  step_q <= ST_MAC;
                end
              end else begin
                state_q <= S_DIV;
              end
            end
          endcase
        end
        S_ACC: begin
          acc_q   <= sat_add(acc_q, qmul_sat(prod_q));
          state_q <= S_RD;
          case (phase_q)
            PH_SCL: step_q <= ST_BIAS;
            PH_HID: begin
              if (j_q == 2'd2) begin
                step_q <= ST_BIAS;
              end else begin
                j_q <= j_q + 2'd1;
              end
            end
            default: begin
              if (last_i) begin
                step_q <= ST_BIAS;
              end else begin
                i_q <= i_q + HW'(1);
              end
            end
          endcase
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_q[k_q] <= div_rsp.quot;
            if (k_q) begin
              state_q <= S_FIN;
            end else begin
              k_q     <= 1'b1;
              i_q     <= '0;
              acc_q   <= '0;
              step_q  <= ST_MAC;
              state_q <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (out_load) begin
            out_q.cod_value   <= res_q[0];
            out_q.uv254_value <= res_q[1];
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == S_DIV))
    else $error("divider busy outside divide state");

  a_predict_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.req_type == REQ_PREDICT)) |=> !in_ready_o)
    else $error("input ready right after predict word");

  a_ex_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EX) |-> ($past(state_q) == S_RD))
    else $error("execute step without memory read");

endmodule

// ===== tb/sv/two_layer_mlp_regressor_core_tb.sv =====
// Testbench for the two-layer MLP regressor core: directed table, then random words.
`timescale 1ns / 1ps

module two_layer_mlp_regressor_core_tb;
  import mlp_pkg::*;

  localparam int H        = 16;
  localparam int DEPTH    = 128;
  localparam int N_USED   = 6 * H + 12;
  localparam int OFS_B1   = 3 * H;
  localparam int OFS_W2   = 4 * H;
  localparam int OFS_B2   = 6 * H;
  localparam int OFS_ISC  = 6 * H + 2;
  localparam int OFS_IMIN = 6 * H + 5;
  localparam int OFS_OMIN = 6 * H + 8;
  localparam int OFS_OSC  = 6 * H + 10;
  localparam int N_RAND   = 1220;

  typedef struct {
    mlp_req_t req;
    bit       typed;
    mlp_rsp_t rsp;
  } stim_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  mlp_req_t in_data;
  logic     out_valid;
  logic     out_ready;
  mlp_rsp_t out_data;

  logic signed [31:0] coef_mem [DEPTH];
  mlp_rsp_t           pending_q [$];
  stim_row_t          dir_tab [$];
  int                 errors;
  int                 send_idle;
  int                 recv_idle;
  bit                 stall_req;

  two_layer_mlp_regressor_core #(
    .HIDDEN_SIZE(H),
    .COEF_DEPTH (DEPTH)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("two_layer_mlp_regressor_core test failed");
    $finish;
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    return sat32((a * b) >>> 16);
  endfunction

  function automatic longint pl_tanh(input longint x);
    longint tab [9] = '{0, 30286, 49911, 59320, 63179, 64659, 65212, 65417, 65492};
    longint ax;
    longint y;
    longint seg;
    ax = (x < 0) ? -x : x;
    if (ax >= 262144) begin
      y = 65492;
    end else begin
      seg = ax >> 15;
      y   = tab[seg] + (((tab[seg + 1] - tab[seg]) * (ax & 32767)) >> 15);
    end
    return (x < 0) ? -y : y;
  endfunction

  function automatic mlp_rsp_t predict_outputs(input mlp_req_t r);
    longint   xs [3];
    longint   hid [H];
    longint   acc;
    longint   sc;
    longint   res [2];
    longint   raw [3];
    mlp_rsp_t o;
    raw[0] = r.absorb_254;
    raw[1] = r.absorb_550;
    raw[2] = r.water_temp;
    for (int j = 0; j < 3; j++) begin
      xs[j] = sat32(fx_mul(raw[j], coef_mem[OFS_ISC + j]) + coef_mem[OFS_IMIN + j]);
    end
    for (int i = 0; i < H; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        acc = sat32(acc + fx_mul(xs[j], coef_mem[i * 3 + j]));
      end
      hid[i] = pl_tanh(sat32(acc + coef_mem[OFS_B1 + i]));
    end
    for (int k = 0; k < 2; k++) begin
      acc = 0;
      for (int i = 0; i < H; i++) begin
        acc = sat32(acc + fx_mul(hid[i], coef_mem[OFS_W2 + k * H + i]));
      end
      acc = sat32(acc + coef_mem[OFS_B2 + k]);
      sc  = coef_mem[OFS_OSC + k];
      if (sc == 0) begin
        res[k] = 0;
      end else begin
        res[k] = sat32((sat32(acc - coef_mem[OFS_OMIN + k]) * 65536) / sc);
      end
    end
    o.cod_value   = res[0][31:0];
    o.uv254_value = res[1][31:0];
    return o;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0;
      default: return 32'(int'($urandom_range(393216)) - 196608);
    endcase
  endfunction

  function automatic mlp_req_t load_word(input int addr, input logic [31:0] v);
    mlp_req_t     r;
    logic [159:0] junk;
    junk         = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r            = junk[$bits(mlp_req_t)-1:0];
    r.req_type   = REQ_LOAD;
    r.coef_addr  = 7'(addr);
    r.coef_value = v;
    return r;
  endfunction

  function automatic mlp_req_t predict_word(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
    mlp_req_t     r;
    logic [159:0] junk;
    junk         = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r            = junk[$bits(mlp_req_t)-1:0];
    r.req_type   = REQ_PREDICT;
    r.absorb_254 = a;
    r.absorb_550 = b;
    r.water_temp = c;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send(input mlp_req_t r, input bit typed, input mlp_rsp_t want);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    if (r.req_type == REQ_LOAD) begin
      coef_mem[r.coef_addr] = r.coef_value;
    end else begin
      pending_q.push_back(typed ? want : predict_outputs(r));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report("unexpected word", out_data.cod_value, 32'h0);
      end else begin
        if (out_data.cod_value !== pending_q[0].cod_value) begin
          report("cod_value", out_data.cod_value, pending_q[0].cod_value);
        end
        if (out_data.uv254_value !== pending_q[0].uv254_value) begin
          report("uv254_value", out_data.uv254_value, pending_q[0].uv254_value);
        end
        void'(pending_q.pop_front());
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    mlp_rsp_t zero_rsp;
    mlp_rsp_t none;
    stim_row_t row;
    int       n_phase;
    zero_rsp  = '0;
    none      = '0;
    errors    = 0;
    send_idle = 6;
    recv_idle = 83;
    stall_req = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    for (int i = 0; i < DEPTH; i++) coef_mem[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_USED; i++) begin
      if (i >= OFS_ISC && i < OFS_OMIN || i >= OFS_OSC) begin
        send(load_word(i, 32'h0001_0000), 1'b0, none);
      end else begin
        send(load_word(i, 32'(int'($urandom_range(131072)) - 65536)), 1'b0, none);
      end
    end

    dir_tab.push_back('{predict_word(32'h0, 32'h0, 32'h0), 1'b0, none});
    dir_tab.push_back('{predict_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, none});
    dir_tab.push_back('{predict_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0, none});
    dir_tab.push_back('{load_word(OFS_OSC, 32'h0), 1'b0, none});
    dir_tab.push_back('{load_word(OFS_OSC + 1, 32'h0), 1'b0, none});
    dir_tab.push_back('{predict_word(32'h0001_0000, 32'hFFFF_0000, 32'h0), 1'b1, zero_rsp});
    dir_tab.push_back('{predict_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678), 1'b1,
                        zero_rsp});
    dir_tab.push_back('{load_word(OFS_OSC, 32'h0001_0000), 1'b0, none});
    dir_tab.push_back('{load_word(OFS_OSC + 1, 32'h7FFF_FFFF), 1'b0, none});
    dir_tab.push_back('{load_word(OFS_ISC, 32'h8000_0000), 1'b0, none});
    dir_tab.push_back('{predict_word(32'h0000_8000, 32'hFFFF_8000, 32'h0003_0000), 1'b0, none});
    dir_tab.push_back('{load_word(OFS_B1, 32'h7FFF_FFFF), 1'b0, none});
    dir_tab.push_back('{load_word(OFS_B1 + 1, 32'h8000_0000), 1'b0, none});
    dir_tab.push_back('{predict_word(32'h0002_0000, 32'h0, 32'hFFFE_0000), 1'b0, none});
    dir_tab.push_back('{load_word(DEPTH - 1, 32'h8000_0000), 1'b0, none});
    dir_tab.push_back('{load_word(N_USED, 32'h7FFF_FFFF), 1'b0, none});
    dir_tab.push_back('{load_word(OFS_OMIN, 32'h7FFF_FFFF), 1'b0, none});
    dir_tab.push_back('{load_word(OFS_OSC + 1, 32'hFFFF_FFFF), 1'b0, none});
    dir_tab.push_back('{predict_word(32'hFFFF_8000, 32'h0000_4000, 32'h0), 1'b0, none});
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      send(row.req, row.typed, row.rsp);
    end

    stall_req = 1'b1;
    for (int n = 0; n < N_RAND; n++) begin
      n_phase = n * 3 / N_RAND;
      send_idle = (n_phase == 0) ? 6 : (n_phase == 1) ? 83 : 0;
      recv_idle = (n_phase == 0) ? 83 : (n_phase == 1) ? 6 : 0;
      if (n == N_RAND / 2) begin
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(99) < 55) begin
        send(load_word($urandom_range(DEPTH - 1), rand_word()), 1'b0, none);
      end else begin
        send(predict_word(rand_word(), rand_word(), rand_word()), 1'b0, none);
      end
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("two_layer_mlp_regressor_core test passed");
    end else begin
      $display("two_layer_mlp_regressor_core test failed");
    end
    $finish;
  end

endmodule
